// ----- src/segment_time_profiler_assert.svh -----
// ----------------------------------------------------------------------------
// Segment time profiler assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TIME_PROFILER_ASSERT_SVH
`define SEGMENT_TIME_PROFILER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define STP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_time_profiler: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define STP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_time_profiler: next-cycle check failed");

`endif

// ----- src/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// Types, codes and defaults shared by the segment time profiler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam int SEGMENTS_DEF     = 8;
    localparam int SPAN_A_PARTS_DEF = 4;
    localparam int SPAN_B_PARTS_DEF = 4;

    localparam int BAND_COUNT = 3;
    localparam int BAND_IW    = 2;

    localparam logic [31:0] BAND_LOW_RESET  = 32'd50;
    localparam logic [31:0] BAND_MID_RESET  = 32'd100;
    localparam logic [31:0] BAND_HIGH_RESET = 32'd200;

    typedef enum logic [2:0] {
        OP_MARK      = 3'd0,
        OP_MARK_SEED = 3'd1,
        OP_WRAP      = 3'd2,
        OP_OPEN_A    = 3'd3,
        OP_MARK_A    = 3'd4,
        OP_MARK_B    = 3'd5,
        OP_CLEAR_MAX = 3'd6,
        OP_READ      = 3'd7
    } opcode_t;

    typedef enum logic [3:0] {
        BANK_PASSES   = 4'd0,
        BANK_PASS_MAX = 4'd1,
        BANK_SEG_SUM  = 4'd2,
        BANK_SEG_MAX  = 4'd3,
        BANK_BAND     = 4'd4,
        BANK_A_SUM    = 4'd5,
        BANK_A_MAX    = 4'd6,
        BANK_B_SUM    = 4'd7,
        BANK_B_MAX    = 4'd8,
        BANK_B_COUNT  = 4'd9
    } bank_t;

    typedef enum logic [1:0] {
        REG_BAND_LOW  = 2'd0,
        REG_BAND_MID  = 2'd1,
        REG_BAND_HIGH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] now_us;
        logic [2:0]  index;
        bank_t       bank;
    } stp_item_t;

    typedef struct packed {
        logic [31:0] band_low_us;
        logic [31:0] band_mid_us;
        logic [31:0] band_high_us;
    } stp_cfg_t;

endpackage

`default_nettype wire

// ----- src/stp_core.sv -----
// ----------------------------------------------------------------------------
// stp_core
// Counter banks of the profiler: executes one item per cycle while exec is
// high and drives the read value of the item being executed.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_core
    import stp_pkg::*;
#(
    parameter int SEGMENTS     = SEGMENTS_DEF,
    parameter int SPAN_A_PARTS = SPAN_A_PARTS_DEF,
    parameter int SPAN_B_PARTS = SPAN_B_PARTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        exec,
    input  wire stp_item_t   item,
    input  wire stp_cfg_t    cfg,
    output logic [31:0]      rd_data
);

    localparam int SIW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int AIW = (SPAN_A_PARTS > 1) ? $clog2(SPAN_A_PARTS) : 1;
    localparam int BIW = (SPAN_B_PARTS > 1) ? $clog2(SPAN_B_PARTS) : 1;

    logic [31:0] last_stamp_reg;
    logic [31:0] pass_start_reg;
    logic [31:0] pass_max_reg;
    logic [31:0] pass_count_reg;
    logic [31:0] band_counts_reg [BAND_COUNT];
    logic [31:0] seg_sums_reg    [SEGMENTS];
    logic [31:0] seg_max_reg     [SEGMENTS];
    logic [31:0] a_last_reg;
    logic [31:0] a_sums_reg      [SPAN_A_PARTS];
    logic [31:0] a_max_reg       [SPAN_A_PARTS];
    logic [31:0] b_last_reg;
    logic [31:0] b_sums_reg      [SPAN_B_PARTS];
    logic [31:0] b_max_reg       [SPAN_B_PARTS];
    logic [31:0] b_counts_reg    [SPAN_B_PARTS];

    logic [SIW-1:0]     seg_sel;
    logic [AIW-1:0]     a_sel;
    logic [BIW-1:0]     b_sel;
    logic [BAND_IW-1:0] band_sel;
    logic               seg_hit;
    logic               a_hit;
    logic               b_hit;
    logic               band_hit;
    logic [31:0]        seg_delta;
    logic [31:0]        a_delta;
    logic [31:0]        b_delta;
    logic [31:0]        period;
    logic               band0;
    logic               band1;
    logic               band2;

    // Decode index and form deltas
    always_comb
    begin
        seg_sel   = item.index[SIW-1:0];
        a_sel     = item.index[AIW-1:0];
        b_sel     = item.index[BIW-1:0];
        band_sel  = item.index[BAND_IW-1:0];
        seg_hit   = {1'b0, item.index} < 4'(SEGMENTS);
        a_hit     = {1'b0, item.index} < 4'(SPAN_A_PARTS);
        b_hit     = {1'b0, item.index} < 4'(SPAN_B_PARTS);
        band_hit  = {1'b0, item.index} < 4'(BAND_COUNT);
        seg_delta = item.now_us - last_stamp_reg;
        a_delta   = item.now_us - a_last_reg;
        b_delta   = item.now_us - b_last_reg;
        period    = item.now_us - pass_start_reg;
        band0     = period >= cfg.band_low_us;
        band1     = band0 && (period >= cfg.band_mid_us);
        band2     = band1 && (period >= cfg.band_high_us);
    end

    // Update counter banks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            pass_start_reg <= '0;
            pass_max_reg   <= '0;
            pass_count_reg <= '0;
            a_last_reg     <= '0;
            b_last_reg     <= '0;
            for (int i = 0; i < BAND_COUNT; i++)
            begin
                band_counts_reg[i] <= '0;
            end
            for (int i = 0; i < SEGMENTS; i++)
            begin
                seg_sums_reg[i] <= '0;
                seg_max_reg[i]  <= '0;
            end
            for (int i = 0; i < SPAN_A_PARTS; i++)
            begin
                a_sums_reg[i] <= '0;
                a_max_reg[i]  <= '0;
            end
            for (int i = 0; i < SPAN_B_PARTS; i++)
            begin
                b_sums_reg[i]   <= '0;
                b_max_reg[i]    <= '0;
                b_counts_reg[i] <= '0;
            end
        end
        else if (exec)
        begin
            unique case (item.op)
                OP_MARK, OP_MARK_SEED, OP_WRAP:
                begin
                    last_stamp_reg <= item.now_us;
                    if (seg_hit)
                    begin
                        seg_sums_reg[seg_sel] <= seg_sums_reg[seg_sel] + seg_delta;
                        if (seg_delta > seg_max_reg[seg_sel])
                        begin
                            seg_max_reg[seg_sel] <= seg_delta;
                        end
                    end
                    if (item.op == OP_MARK_SEED)
                    begin
                        b_last_reg <= item.now_us;
                    end
                    if (item.op == OP_WRAP)
                    begin
                        // period ends at the new last stamp, which is now_us
                        if (period > pass_max_reg)
                        begin
                            pass_max_reg <= period;
                        end
                        pass_start_reg <= item.now_us;
                        pass_count_reg <= pass_count_reg + 32'd1;
                        if (band0)
                        begin
                            band_counts_reg[0] <= band_counts_reg[0] + 32'd1;
                        end
                        if (band1)
                        begin
                            band_counts_reg[1] <= band_counts_reg[1] + 32'd1;
                        end
                        if (band2)
                        begin
                            band_counts_reg[2] <= band_counts_reg[2] + 32'd1;
                        end
                    end
                end
                OP_OPEN_A:
                begin
                    a_last_reg <= last_stamp_reg;
                end
                OP_MARK_A:
                begin
                    a_last_reg <= item.now_us;
                    if (a_hit)
                    begin
                        a_sums_reg[a_sel] <= a_sums_reg[a_sel] + a_delta;
                        if (a_delta > a_max_reg[a_sel])
                        begin
                            a_max_reg[a_sel] <= a_delta;
                        end
                    end
                end
                OP_MARK_B:
                begin
                    b_last_reg <= item.now_us;
                    if (b_hit)
                    begin
                        b_counts_reg[b_sel] <= b_counts_reg[b_sel] + 32'd1;
                        b_sums_reg[b_sel]   <= b_sums_reg[b_sel] + b_delta;
                        if (b_delta > b_max_reg[b_sel])
                        begin
                            b_max_reg[b_sel] <= b_delta;
                        end
                    end
                end
                OP_CLEAR_MAX:
                begin
                    pass_max_reg <= '0;
                    for (int i = 0; i < SEGMENTS; i++)
                    begin
                        seg_max_reg[i] <= '0;
                    end
                    for (int i = 0; i < SPAN_A_PARTS; i++)
                    begin
                        a_max_reg[i] <= '0;
                    end
                    for (int i = 0; i < SPAN_B_PARTS; i++)
                    begin
                        b_max_reg[i] <= '0;
                    end
                end
                OP_READ:
                begin
                end
            endcase
        end
    end

    // Select the counter for a read
    always_comb
    begin
        unique case (item.bank)
            BANK_PASSES:   rd_data = pass_count_reg;
            BANK_PASS_MAX: rd_data = pass_max_reg;
            BANK_SEG_SUM:  rd_data = seg_hit  ? seg_sums_reg[seg_sel]     : '0;
            BANK_SEG_MAX:  rd_data = seg_hit  ? seg_max_reg[seg_sel]      : '0;
            BANK_BAND:     rd_data = band_hit ? band_counts_reg[band_sel] : '0;
            BANK_A_SUM:    rd_data = a_hit    ? a_sums_reg[a_sel]         : '0;
            BANK_A_MAX:    rd_data = a_hit    ? a_max_reg[a_sel]          : '0;
            BANK_B_SUM:    rd_data = b_hit    ? b_sums_reg[b_sel]         : '0;
            BANK_B_MAX:    rd_data = b_hit    ? b_max_reg[b_sel]          : '0;
            BANK_B_COUNT:  rd_data = b_hit    ? b_counts_reg[b_sel]       : '0;
            default:       rd_data = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/segment_time_profiler.sv -----
// Segment time profiler: takes one item per clock cycle with no stalls of its
// own, save for the read stall below. An accepted item sits in the input
// register, where it updates the counter banks with one subtract, add and
// compare per bank; a read item places its counter value in the output
// register as it executes, and the result shows on the master side from that
// register. The input side stalls only while the output register holds a
// result that has not been taken and the held item is a read. Band thresholds
// are written through the configuration channel, which is always ready.
// ----------------------------------------------------------------------------
// segment_time_profiler
// Top level: input register, output register, band thresholds and checks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_time_profiler_assert.svh"

module segment_time_profiler
    import stp_pkg::*;
#(
    parameter int SEGMENTS     = SEGMENTS_DEF,
    parameter int SPAN_A_PARTS = SPAN_A_PARTS_DEF,
    parameter int SPAN_B_PARTS = SPAN_B_PARTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // now_us[31:0], index[34:32], read_bank[38:35]
    input  wire logic [2:0]  s_axis_tuser,   // opcode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // read_data[31:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic        in_valid_reg;
    stp_item_t   in_item_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    stp_cfg_t    cfg_reg;
    logic        out_free;
    logic        exec;
    logic        is_read;
    logic [31:0] rd_data;

    // Issue the held item when its result has somewhere to go
    always_comb
    begin
        is_read       = in_item_reg.op == OP_READ;
        out_free      = !out_valid_reg || m_axis_tready;
        exec          = in_valid_reg && (!is_read || out_free);
        s_axis_tready = !in_valid_reg || exec;
        cfg_ready     = 1'b1;
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = out_data_reg;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.op     <= opcode_t'(s_axis_tuser);
            in_item_reg.now_us <= s_axis_tdata[31:0];
            in_item_reg.index  <= s_axis_tdata[34:32];
            in_item_reg.bank   <= bank_t'(s_axis_tdata[38:35]);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec && is_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && is_read)
        begin
            out_data_reg <= rd_data;
        end
    end

    // Band thresholds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low_us  <= BAND_LOW_RESET;
            cfg_reg.band_mid_us  <= BAND_MID_RESET;
            cfg_reg.band_high_us <= BAND_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BAND_LOW:  cfg_reg.band_low_us  <= cfg_data;
                REG_BAND_MID:  cfg_reg.band_mid_us  <= cfg_data;
                REG_BAND_HIGH: cfg_reg.band_high_us <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    stp_core #(
        .SEGMENTS     (SEGMENTS),
        .SPAN_A_PARTS (SPAN_A_PARTS),
        .SPAN_B_PARTS (SPAN_B_PARTS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec    (exec),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .rd_data (rd_data)
    );

    // A read that executes always lands in the output register
    `STP_ASSERT_NEXT(a_read_lands, exec && is_read, m_axis_tvalid && (m_axis_tdata == $past(rd_data)))
    // A held item that cannot issue stays in place
    `STP_ASSERT_NEXT(a_hold_item, in_valid_reg && !exec, in_valid_reg && $stable(in_item_reg))
    // No result appears without a read executing
    `STP_ASSERT_NEXT(a_no_spurious, !m_axis_tvalid && !(exec && is_read), !m_axis_tvalid)
    // A stalled input side means a read waits on a full output
    `STP_ASSERT_SAME(a_stall_cause, !s_axis_tready, is_read && out_valid_reg && !m_axis_tready)

endmodule

`default_nettype wire

// ----- dv/segment_time_profiler_tb.sv -----
// ----------------------------------------------------------------------------
// segment_time_profiler_tb
// Self-checking bench for the segment time profiler. A scoreboard model keeps
// its own copy of every counter bank and the band thresholds, updates them on
// each accepted item, and queues the value that each read must return. Results
// on the master side are compared against that queue in order. Stimulus runs
// directed corner items, then well-formed profiling passes with random content
// under several threshold settings, random noise and a long output stall.
// ----------------------------------------------------------------------------

module segment_time_profiler_tb;
    import stp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [3:0]  bank;
        logic [2:0]  index;
        logic [31:0] value;
    } read_expect_t;

    // DUT ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // now_us[31:0], index[34:32], read_bank[38:35]
    logic [2:0]  s_axis_tuser = '0;   // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // read_data[31:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Scoreboard copy of the profiler state
    logic [31:0] band_low;
    logic [31:0] band_mid;
    logic [31:0] band_high;
    logic [31:0] last_stamp;
    logic [31:0] pass_start;
    logic [31:0] pass_max;
    logic [31:0] pass_count;
    logic [31:0] band_counts [BAND_COUNT];
    logic [31:0] seg_sums [SEGMENTS_DEF];
    logic [31:0] seg_maxima [SEGMENTS_DEF];
    logic [31:0] span_a_last;
    logic [31:0] span_a_sums [SPAN_A_PARTS_DEF];
    logic [31:0] span_a_maxima [SPAN_A_PARTS_DEF];
    logic [31:0] span_b_last;
    logic [31:0] span_b_sums [SPAN_B_PARTS_DEF];
    logic [31:0] span_b_maxima [SPAN_B_PARTS_DEF];
    logic [31:0] span_b_counts [SPAN_B_PARTS_DEF];

    read_expect_t expected_reads [$];
    read_expect_t head_read;

    logic [31:0] clock_us = '0;
    int          items_sent = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          rx_hold_len = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    segment_time_profiler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------

    // Clear the model to its post-reset state
    task automatic clear_profile();
        band_low = BAND_LOW_RESET;
        band_mid = BAND_MID_RESET;
        band_high = BAND_HIGH_RESET;
        last_stamp = '0;
        pass_start = '0;
        pass_max = '0;
        pass_count = '0;
        span_a_last = '0;
        span_b_last = '0;
        foreach (band_counts[i]) band_counts[i] = '0;
        foreach (seg_sums[i])
        begin
            seg_sums[i] = '0;
            seg_maxima[i] = '0;
        end
        foreach (span_a_sums[i])
        begin
            span_a_sums[i] = '0;
            span_a_maxima[i] = '0;
        end
        foreach (span_b_sums[i])
        begin
            span_b_sums[i] = '0;
            span_b_maxima[i] = '0;
            span_b_counts[i] = '0;
        end
    endtask

    // Apply one accepted item to the model; queue the value a read returns
    task automatic predict_profile(input stp_item_t it);
        logic [31:0]  delta;
        logic [31:0]  period;
        read_expect_t rd;
        int           idx;
        idx = int'(it.index);
        case (it.op)
            OP_MARK, OP_MARK_SEED, OP_WRAP:
            begin
                delta = it.now_us - last_stamp;
                if (idx < SEGMENTS_DEF)
                begin
                    seg_sums[idx] += delta;
                    if (delta > seg_maxima[idx])
                        seg_maxima[idx] = delta;
                end
                last_stamp = it.now_us;
                if (it.op == OP_MARK_SEED)
                    span_b_last = last_stamp;
                if (it.op == OP_WRAP)
                begin
                    period = last_stamp - pass_start;
                    if (period > pass_max)
                        pass_max = period;
                    pass_start = last_stamp;
                    pass_count += 1;
                    // bands nest: each is tested only if the one below counted
                    if (period >= band_low)
                    begin
                        band_counts[0] += 1;
                        if (period >= band_mid)
                        begin
                            band_counts[1] += 1;
                            if (period >= band_high)
                                band_counts[2] += 1;
                        end
                    end
                end
            end
            OP_OPEN_A:
                span_a_last = last_stamp;
            OP_MARK_A:
            begin
                delta = it.now_us - span_a_last;
                if (idx < SPAN_A_PARTS_DEF)
                begin
                    span_a_sums[idx] += delta;
                    if (delta > span_a_maxima[idx])
                        span_a_maxima[idx] = delta;
                end
                span_a_last = it.now_us;
            end
            OP_MARK_B:
            begin
                delta = it.now_us - span_b_last;
                if (idx < SPAN_B_PARTS_DEF)
                begin
                    span_b_counts[idx] += 1;
                    span_b_sums[idx] += delta;
                    if (delta > span_b_maxima[idx])
                        span_b_maxima[idx] = delta;
                end
                span_b_last = it.now_us;
            end
            OP_CLEAR_MAX:
            begin
                pass_max = '0;
                foreach (seg_maxima[i]) seg_maxima[i] = '0;
                foreach (span_a_maxima[i]) span_a_maxima[i] = '0;
                foreach (span_b_maxima[i]) span_b_maxima[i] = '0;
            end
            default:
            begin
                rd.bank = it.bank;
                rd.index = it.index;
                rd.value = '0;
                case (it.bank)
                    BANK_PASSES:   rd.value = pass_count;
                    BANK_PASS_MAX: rd.value = pass_max;
                    BANK_SEG_SUM:  if (idx < SEGMENTS_DEF) rd.value = seg_sums[idx];
                    BANK_SEG_MAX:  if (idx < SEGMENTS_DEF) rd.value = seg_maxima[idx];
                    BANK_BAND:     if (idx < BAND_COUNT) rd.value = band_counts[idx];
                    BANK_A_SUM:    if (idx < SPAN_A_PARTS_DEF) rd.value = span_a_sums[idx];
                    BANK_A_MAX:    if (idx < SPAN_A_PARTS_DEF) rd.value = span_a_maxima[idx];
                    BANK_B_SUM:    if (idx < SPAN_B_PARTS_DEF) rd.value = span_b_sums[idx];
                    BANK_B_MAX:    if (idx < SPAN_B_PARTS_DEF) rd.value = span_b_maxima[idx];
                    BANK_B_COUNT:  if (idx < SPAN_B_PARTS_DEF) rd.value = span_b_counts[idx];
                    default:       rd.value = '0;
                endcase
                expected_reads.push_back(rd);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic stp_item_t make_item(opcode_t op, logic [31:0] now_us,
                                            logic [2:0] index, logic [3:0] bank);
        stp_item_t it;
        it.op = op;
        it.now_us = now_us;
        it.index = index;
        it.bank = bank_t'(bank);
        return it;
    endfunction

    // Send one item after a random gap and update the model on acceptance
    task automatic send_item(input stp_item_t it);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.bank, it.index, it.now_us};
        s_axis_tuser  <= it.op;
        do @(posedge clk); while (!s_axis_tready);
        predict_profile(it);
        items_sent++;
    endtask

    // Write one band threshold; valid stays up for the caller to drop
    task automatic write_band(input reg_idx_t reg_sel, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (reg_sel)
            REG_BAND_LOW:  band_low = value;
            REG_BAND_MID:  band_mid = value;
            REG_BAND_HIGH: band_high = value;
            default:       ;
        endcase
    endtask

    // Write all three thresholds back to back, then drop valid
    task automatic write_bands(input logic [31:0] low, input logic [31:0] mid,
                               input logic [31:0] high);
        write_band(REG_BAND_LOW, low);
        write_band(REG_BAND_MID, mid);
        write_band(REG_BAND_HIGH, high);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every pending read, then let the pipeline drain
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Advance the timestamp: mostly small steps, sometimes jumps or wraps
    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 15))
            0:       clock_us = $urandom;
            1:       clock_us = clock_us + $urandom_range(1000, 100000);
            default: clock_us = clock_us + $urandom_range(0, 60);
        endcase
        return clock_us;
    endfunction

    // Read a random counter, mostly with a valid bank and index
    task automatic send_read();
        logic [3:0] bank;
        logic [2:0] index;
        bank = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 9))
                                           : 4'($urandom_range(10, 15));
        case (bank)
            BANK_SEG_SUM, BANK_SEG_MAX: index = 3'($urandom_range(0, 7));
            BANK_BAND:                  index = 3'($urandom_range(0, 2));
            default:                    index = 3'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 3) == 0)
            index = 3'($urandom);
        send_item(make_item(OP_READ, $urandom, index, bank));
    endtask

    // One profiling pass: optional sub-span open, a few marks, a wrap, reads and a rare max clear
    task automatic run_pass();
        int marks;
        int k;
        marks = $urandom_range(0, 5);
        if ($urandom_range(0, 1) != 0)
            send_item(make_item(OP_OPEN_A, $urandom, 3'($urandom), 4'($urandom)));
        for (k = 0; k < marks; k++)
        begin
            case ($urandom_range(0, 5))
                0, 1: send_item(make_item(OP_MARK, next_stamp(), 3'($urandom),
                                          4'($urandom)));
                2:    send_item(make_item(OP_MARK_SEED, next_stamp(), 3'($urandom),
                                          4'($urandom)));
                3:    send_item(make_item(OP_MARK_A, next_stamp(),
                                          3'($urandom_range(0, 4)), 4'($urandom)));
                4:    send_item(make_item(OP_MARK_B, next_stamp(),
                                          3'($urandom_range(0, 4)), 4'($urandom)));
                default: send_read();
            endcase
        end
        send_item(make_item(OP_WRAP, next_stamp(), 3'($urandom), 4'($urandom)));
        repeat ($urandom_range(0, 3)) send_read();
        if ($urandom_range(0, 30) == 0)
            send_item(make_item(OP_CLEAR_MAX, $urandom, 3'($urandom), 4'($urandom)));
    endtask

    // Run passes until the item budget is spent
    task automatic run_passes(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
            run_pass();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner items on the reset thresholds
    task automatic test_directed_corners();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_item(make_item(OP_READ, 32'd0, 3'd0, BANK_PASSES));
        send_item(make_item(OP_READ, 32'd0, 3'd0, BANK_SEG_SUM));
        send_item(make_item(OP_MARK, 32'd100, 3'd0, BANK_PASSES));
        send_item(make_item(OP_MARK, 32'hFFFF_FFFF, 3'd7, BANK_PASSES));
        // timestamp wraps through zero
        send_item(make_item(OP_MARK, 32'd5, 3'd7, BANK_PASSES));
        send_item(make_item(OP_MARK_SEED, 32'd40, 3'd3, BANK_PASSES));
        send_item(make_item(OP_WRAP, 32'd300, 3'd2, BANK_PASSES));
        send_item(make_item(OP_OPEN_A, 32'hDEAD_BEEF, 3'd0, BANK_PASSES));
        send_item(make_item(OP_MARK_A, 32'd310, 3'd0, BANK_PASSES));
        // part out of range: stamp advances, nothing is charged
        send_item(make_item(OP_MARK_A, 32'd350, 3'd4, BANK_PASSES));
        send_item(make_item(OP_MARK_A, 32'd360, 3'd3, BANK_PASSES));
        send_item(make_item(OP_MARK_B, 32'd500, 3'd0, BANK_PASSES));
        send_item(make_item(OP_MARK_B, 32'd520, 3'd7, BANK_PASSES));
        send_item(make_item(OP_MARK_B, 32'd530, 3'd3, BANK_PASSES));
        // short pass below every band
        send_item(make_item(OP_WRAP, 32'd320, 3'd1, BANK_PASSES));
        send_item(make_item(OP_READ, 32'd0, 3'd0, BANK_PASS_MAX));
        send_item(make_item(OP_READ, 32'd0, 3'd7, BANK_SEG_SUM));
        send_item(make_item(OP_READ, 32'd0, 3'd7, BANK_SEG_MAX));
        send_item(make_item(OP_READ, 32'd0, 3'd2, BANK_BAND));
        send_item(make_item(OP_READ, 32'd0, 3'd3, BANK_BAND));
        send_item(make_item(OP_READ, 32'd0, 3'd3, BANK_A_MAX));
        send_item(make_item(OP_READ, 32'd0, 3'd3, BANK_B_COUNT));
        send_item(make_item(OP_READ, 32'd0, 3'd7, BANK_B_SUM));
        // unknown bank reads zero
        send_item(make_item(OP_READ, 32'hFFFF_FFFF, 3'd7, 4'd12));
        send_item(make_item(OP_CLEAR_MAX, 32'd0, 3'd0, BANK_PASSES));
        send_item(make_item(OP_READ, 32'd0, 3'd7, BANK_SEG_MAX));
    endtask

    // Passes on the reset thresholds
    task automatic test_default_bands();
        run_passes(220);
    endtask

    // Everything counts in band 0, almost nothing reaches band 2; no idling
    task automatic test_band_extremes();
        settle_block();
        write_bands(32'd0, 32'd1, 32'hFFFF_FFFF);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_passes(220);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Thresholds out of order: bands must still nest
    task automatic test_unordered_bands();
        settle_block();
        write_bands(32'd150, 32'd20, 32'd80);
        run_passes(220);
    endtask

    // Top threshold at the low band, zero above it
    task automatic test_band_ceiling();
        settle_block();
        write_bands(32'hFFFF_FFFF, 32'd0, 32'd0);
        run_passes(220);
    endtask

    // Random thresholds in the range the pass periods reach
    task automatic test_random_bands();
        repeat (2)
        begin
            settle_block();
            write_bands($urandom_range(0, 300), $urandom_range(0, 300),
                        $urandom_range(0, 300));
            run_passes(100);
        end
    endtask

    // Fully random items mixed with passes
    task automatic test_random_noise();
        int stop_at;
        stop_at = items_sent + 300;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 1) != 0)
                send_item(make_item(opcode_t'($urandom_range(0, 7)), $urandom,
                                    3'($urandom), 4'($urandom)));
            else
                run_pass();
        end
    endtask

    // Hold the output for a long stretch while items keep coming
    task automatic test_output_backpressure();
        settle_block();
        write_bands(BAND_LOW_RESET, BAND_MID_RESET, BAND_HIGH_RESET);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_len = 300;
        repeat (50)
        begin
            send_read();
            send_read();
            send_item(make_item(OP_MARK, next_stamp(), 3'($urandom), 4'($urandom)));
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial
    begin
        clear_profile();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_default_bands();
        test_band_extremes();
        test_unordered_bands();
        test_band_ceiling();
        test_random_bands();
        test_random_noise();
        test_output_backpressure();

        settle_block();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("segment_time_profiler_tb: PASS");
        else
            $display("segment_time_profiler_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the output randomly, or for a long hold when one is requested
    initial
    begin : result_sink
        int stall;
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                stall = rx_idle_en ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input read_expect_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s: bank %0d index %0d read %h, model %h",
                     $time, what, want.bank, want.index, got, want.value);
    endtask

    // Compare each result with the oldest pending read
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_reads.size() == 0)
            begin
                head_read = '{default: '0};
                report_mismatch("result with no read pending", m_axis_tdata, head_read);
            end
            else
            begin
                head_read = expected_reads.pop_front();
                if (m_axis_tdata !== head_read.value)
                    report_mismatch("read_data mismatch", m_axis_tdata, head_read);
            end
        end
    end

    // Stop the run if no handshake completes for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles, %0d reads pending",
                     $time, quiet_cycles, expected_reads.size());
            $display("segment_time_profiler_tb: FAIL");
            $finish;
        end
    end

endmodule

// ----- segment_time_profiler.f -----
+incdir+src
src/stp_pkg.sv
src/stp_core.sv
src/segment_time_profiler.sv
dv/segment_time_profiler_tb.sv
